@@ hw/rtl/mqta_pkg.sv @@
// Shared types, widths and codes of the multi-queue task arbiter.
package mqta_pkg;

  localparam int TASK_NODES  = 256;
  localparam int NODE_W      = $clog2(TASK_NODES);
  localparam int LINK_W      = NODE_W + 1;
  localparam int QUEUE_COUNT = 12;
  localparam int QUEUE_W     = 4;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int DISPATCH_W  = 5;
  localparam int BUSY_W      = 7;

  // A link or queue pointer that equals the node count marks an empty list.
  localparam logic [LINK_W-1:0] NIL_NODE = LINK_W'(TASK_NODES);

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_CLAIM   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERF_WORKERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EFF_WORKERS  = 2'd2;

  localparam logic [1:0] CLS_ANY   = 2'd0;
  localparam logic [1:0] CLS_HEAVY = 2'd1;
  localparam logic [1:0] CLS_LIGHT = 2'd2;
  localparam logic [1:0] CLS_MAIN  = 2'd3;

  localparam logic [1:0] AFF_PERF = 2'd1;
  localparam logic [1:0] AFF_EFF  = 2'd2;

  localparam logic [1:0] PRI_CRITICAL   = 2'd0;
  localparam logic [1:0] PRI_NORMAL     = 2'd1;
  localparam logic [1:0] PRI_BACKGROUND = 2'd2;
  localparam logic [1:0] PRI_INVALID    = 2'd3;

  // Dispatch counter values at which a lower priority is served first.
  localparam logic [DISPATCH_W-1:0] AGE_BACKGROUND = 5'd31;
  localparam logic [2:0]            AGE_NORMAL     = 3'd7;

  typedef struct packed {
    logic                op;
    logic [NODE_W-1:0]   task_index;
    logic [1:0]          priority_req;
    logic [1:0]          cost_class;
    logic                for_main_thread;
    logic [1:0]          affinity;
    logic                from_main_thread;
    logic                cooperative;
    logic [BUSY_W-1:0]   busy_performance;
    logic [BUSY_W-1:0]   busy_efficiency;
    logic                executing;
  } in_t;

  typedef struct packed {
    logic              granted;
    logic [NODE_W-1:0] granted_index;
  } out_t;

endpackage

@@ hw/rtl/multi_queue_task_arbiter_core.sv @@
// Top level of the multi-queue task arbiter: twelve linked-list ready queues.
// A claim passes through POP, and an enqueue onto a non-empty queue through LINK; other enqueues stay in IDLE.
// A claim gives its result from the result register after POP, one strobe cycle long.
// Busy is high while the block is in LINK or POP, that is after a claim or an enqueue that must link.
// The receiver cannot stall; the next-link memory, with one write and one read port, sets the rate.
// Synchronous active-low reset empties all queues and clears counter and config.
module multi_queue_task_arbiter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  mqta_pkg::in_t                   in_data,
  output logic                            out_valid,
  output mqta_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mqta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mqta_pkg::CFG_W-1:0]      cfg_data
);
  import mqta_pkg::*;

  // IDLE takes a transfer; LINK writes the old tail's link on an enqueue;
  // POP retires a claim once the popped node's link has been read.
  typedef enum logic [1:0] {ST_IDLE, ST_LINK, ST_POP} state_t;

  state_t                 state_r;
  logic [LINK_W-1:0]      head_r [QUEUE_COUNT];
  logic [LINK_W-1:0]      tail_r [QUEUE_COUNT];
  logic [DISPATCH_W-1:0]  dispatch_r;
  logic [CFG_W-1:0]       worker_count_r;
  logic [CFG_W-1:0]       perf_workers_r;
  logic [CFG_W-1:0]       eff_workers_r;
  logic                   out_valid_r;
  out_t                   out_data_r;

  // Values carried from the accepting cycle into LINK or POP.
  logic [NODE_W-1:0]      link_node_r;
  logic [NODE_W-1:0]      link_value_r;
  logic [QUEUE_W-1:0]     pop_q_r;
  logic [NODE_W-1:0]      pop_node_r;
  logic                   pop_found_r;

  // The next-link memory: one entry per task node, one write and one read port.
  logic [LINK_W-1:0]      link_mem [TASK_NODES];
  logic [LINK_W-1:0]      link_rd_r;
  logic                   mem_we;
  logic [NODE_W-1:0]      mem_waddr;
  logic [LINK_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [NODE_W-1:0]      mem_raddr;

  logic                   accept;
  logic [1:0]             enq_cls;
  logic                   enq_ok;
  logic [QUEUE_W-1:0]     enq_q;
  logic [LINK_W-1:0]      enq_tail;
  logic                   enq_has_tail;

  logic                   aff_perf;
  logic                   aff_eff;
  logic                   aff_any;
  logic                   refused;
  logic [3:0]             elig;
  logic [1:0]             cls_order [4];
  logic [1:0]             pri_order [3];
  logic                   found;
  logic [QUEUE_W-1:0]     sel_q;
  logic [LINK_W-1:0]      sel_node;
  logic [DISPATCH_W-1:0]  dispatch_nxt;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Enqueue decode. A main-thread task goes to the main-thread class; a cost
  // code equal to that class code is invalid for other tasks, whose enqueue is dropped.
  assign enq_cls      = in_data.for_main_thread ? CLS_MAIN : in_data.cost_class;
  assign enq_ok       = (in_data.priority_req != PRI_INVALID) &&
                        (in_data.for_main_thread || in_data.cost_class != CLS_MAIN) &&
                        (LINK_W'(in_data.task_index) < NIL_NODE);
  assign enq_q        = {in_data.priority_req, enq_cls};
  assign enq_tail     = tail_r[enq_q];
  assign enq_has_tail = (enq_tail != NIL_NODE);

  // Claim eligibility per class. The unused affinity code counts as "any".
  assign aff_perf = (in_data.affinity == AFF_PERF);
  assign aff_eff  = (in_data.affinity == AFF_EFF);
  assign aff_any  = !aff_perf && !aff_eff;
  assign refused  = (in_data.from_main_thread && worker_count_r != '0 &&
                     !in_data.cooperative) ||
                    (!in_data.from_main_thread && !in_data.executing);

  always_comb begin
    elig[CLS_MAIN]  = in_data.from_main_thread;
    elig[CLS_ANY]   = !refused;
    elig[CLS_HEAVY] = !refused && (in_data.cooperative || aff_any || aff_perf ||
                                   in_data.busy_performance >= perf_workers_r);
    elig[CLS_LIGHT] = !refused && (in_data.cooperative || aff_any || aff_eff ||
                                   in_data.busy_efficiency >= eff_workers_r);
  end

  // Class order: main thread first, then the class the affinity prefers,
  // then "any", then the remaining cost class.
  always_comb begin
    cls_order[0] = CLS_MAIN;
    cls_order[1] = aff_eff ? CLS_LIGHT : CLS_HEAVY;
    cls_order[2] = CLS_ANY;
    cls_order[3] = aff_eff ? CLS_HEAVY : CLS_LIGHT;
  end

  // Ageing: every 32nd dispatch serves background first, the other 8th ones normal.
  always_comb begin
    if (dispatch_r == AGE_BACKGROUND) begin
      pri_order[0] = PRI_BACKGROUND;
      pri_order[1] = PRI_CRITICAL;
      pri_order[2] = PRI_NORMAL;
    end else if (dispatch_r[2:0] == AGE_NORMAL) begin
      pri_order[0] = PRI_NORMAL;
      pri_order[1] = PRI_CRITICAL;
      pri_order[2] = PRI_BACKGROUND;
    end else begin
      pri_order[0] = PRI_CRITICAL;
      pri_order[1] = PRI_NORMAL;
      pri_order[2] = PRI_BACKGROUND;
    end
  end

  // Scan the twelve queues in claim order from the back, so that the earliest
  // non-empty eligible queue is the one left selected.
  always_comb begin
    logic [QUEUE_W-1:0] q;
    found = 1'b0;
    sel_q = '0;
    q     = '0;
    for (int p = 2; p >= 0; p--) begin
      for (int k = 3; k >= 0; k--) begin
        q = {pri_order[p], cls_order[k]};
        if (head_r[q] != NIL_NODE && elig[cls_order[k]]) begin
          found = 1'b1;
          sel_q = q;
        end
      end
    end
  end

  assign sel_node     = head_r[sel_q];
  assign dispatch_nxt = dispatch_r + DISPATCH_W'(1);

  // Memory port control. An enqueue first terminates the new node's link and
  // only then links the old tail to it, so a node enqueued behind itself
  // ends up pointing at itself. A claim reads the head's link on acceptance
  // and terminates the popped node's link in POP.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = NIL_NODE;
    mem_re    = 1'b0;
    mem_raddr = sel_node[NODE_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.op == OP_ENQUEUE && enq_ok) begin
          mem_we    = 1'b1;
          mem_waddr = in_data.task_index;
        end
        if (accept && in_data.op == OP_CLAIM) begin
          mem_re = 1'b1;
        end
      end
      ST_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = link_node_r;
        mem_wdata = LINK_W'(link_value_r);
      end
      ST_POP: begin
        mem_we    = pop_found_r;
        mem_waddr = pop_node_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rd_r <= link_mem[mem_raddr];
    end
  end

  // Sequencer, queue pointers, dispatch counter, configuration and result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      dispatch_r     <= '0;
      worker_count_r <= '0;
      perf_workers_r <= '0;
      eff_workers_r  <= '0;
      out_valid_r    <= 1'b0;
      out_data_r     <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_r[i] <= NIL_NODE;
        tail_r[i] <= NIL_NODE;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WORKER_COUNT: worker_count_r <= cfg_data;
          CFG_PERF_WORKERS: perf_workers_r <= cfg_data;
          CFG_EFF_WORKERS:  eff_workers_r  <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.op == OP_ENQUEUE) begin
              if (enq_ok) begin
                tail_r[enq_q] <= LINK_W'(in_data.task_index);
                if (enq_has_tail) begin
                  state_r <= ST_LINK;
                end else begin
                  head_r[enq_q] <= LINK_W'(in_data.task_index);
                end
              end
            end else begin
              state_r <= ST_POP;
            end
          end
        end
        ST_LINK: begin
          state_r <= ST_IDLE;
        end
        ST_POP: begin
          if (pop_found_r) begin
            head_r[pop_q_r] <= link_rd_r;
            if (tail_r[pop_q_r] == LINK_W'(pop_node_r)) begin
              tail_r[pop_q_r] <= NIL_NODE;
            end
            dispatch_r <= dispatch_nxt;
          end
          out_valid_r              <= 1'b1;
          out_data_r.granted       <= pop_found_r;
          out_data_r.granted_index <= pop_found_r ? pop_node_r : '0;
          state_r                  <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      link_node_r  <= enq_tail[NODE_W-1:0];
      link_value_r <= in_data.task_index;
      pop_q_r      <= sel_q;
      pop_node_r   <= sel_node[NODE_W-1:0];
      pop_found_r  <= found;
    end
  end

endmodule

@@ hw/rtl/mqta_checker.sv @@
// Port-level assertions for the multi-queue task arbiter and their binding.
module mqta_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input mqta_pkg::in_t   in_data,
  input logic            out_valid,
  input mqta_pkg::out_t  out_data
);
  import mqta_pkg::*;

  logic claim_acc;
  assign claim_acc = start && !busy && in_data.op == OP_CLAIM;

  // Every result answers a claim accepted ahead of POP and the result register.
  a_result_from_claim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(claim_acc, 2))
    else $error("result without a matching claim");

  // Every accepted claim is answered once POP has set the result register.
  a_claim_answered: assert property (@(posedge clk) disable iff (!rst_n)
    claim_acc |-> ##2 out_valid)
    else $error("claim not answered");

  // A claim keeps the block busy for the following cycle.
  a_claim_busy: assert property (@(posedge clk) disable iff (!rst_n)
    claim_acc |=> busy)
    else $error("claim did not hold busy");

  // A refused claim reports node zero.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.granted) |-> out_data.granted_index == '0)
    else $error("refused claim with non-zero index");

endmodule

bind multi_queue_task_arbiter_core mqta_checker u_mqta_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the multi-queue task arbiter core, with its own predictor.
`timescale 1ns / 100ps

module tb;
  import mqta_pkg::*;

  // Affinity codes that the package leaves unnamed: code three behaves as "any".
  localparam logic [1:0] AFF_ANY      = 2'd0;
  localparam logic [1:0] AFF_RESERVED = 2'd3;

  localparam int CLASSES_PER_PRIORITY = 4;
  localparam int ITEM_TOTAL           = 1900;
  localparam int PHASES               = 6;
  // A claim answers through POP and the result register, and an enqueue may hold busy
  // in LINK, so these quiet cycles are enough before touching the registers.
  localparam int SETTLE_CYCLES        = 4;
  localparam int DRAIN_CYCLES         = 8;
  localparam int CYCLE_LIMIT          = 200000;
  localparam int REPORT_LIMIT         = 10;

  localparam out_t NO_GRANT = '0;

  // One row of the directed part: the item, and a hand-written grant where the
  // answer is obvious. Rows without one are checked against the predictor.
  typedef struct packed {
    in_t  item;
    logic typed;
    out_t grant;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_t                  in_data;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor copy of the queues, the link memory, the ageing counter and the
  // worker registers.
  logic [LINK_W-1:0]     head_q   [QUEUE_COUNT];
  logic [LINK_W-1:0]     tail_q   [QUEUE_COUNT];
  logic [LINK_W-1:0]     link_mem [TASK_NODES];
  logic [DISPATCH_W-1:0] dispatch_ctr;
  logic [CFG_W-1:0]      cfg_workers;
  logic [CFG_W-1:0]      cfg_perf;
  logic [CFG_W-1:0]      cfg_eff;

  // Stimulus bookkeeping: which nodes are believed to sit in a queue, so that
  // most enqueues use a free node and the lists stay well formed.
  bit node_queued [TASK_NODES];

  out_t      expected_grants [$];
  stim_row_t directed_rows   [$];
  int        mismatch_count;
  int        cycle_count;

  // Register settings per random phase; a negative entry means a random value.
  int workers_plan [PHASES] = '{64, 0, 1, 0, -1, -1};
  int perf_plan    [PHASES] = '{64, 0, 0, 64, -1, -1};
  int eff_plan     [PHASES] = '{64, 0, 64, 0, -1, -1};

  multi_queue_task_arbiter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH (cycle %0d): %s", cycle_count, msg);
    end
  endtask

  // Appends one row to the directed table.
  task automatic add_row(in_t item, logic typed, out_t grant);
    stim_row_t row;
    row.item      = item;
    row.typed     = typed;
    row.grant     = grant;
    directed_rows = {directed_rows, row};
  endtask

  function automatic in_t enqueue_item(logic [NODE_W-1:0] idx, logic [1:0] pri,
                                       logic [1:0] cls, logic for_main);
    in_t it;
    it = '0;
    it.op              = OP_ENQUEUE;
    it.task_index      = idx;
    it.priority_req    = pri;
    it.cost_class      = cls;
    it.for_main_thread = for_main;
    return it;
  endfunction

  function automatic in_t claim_item(logic [1:0] aff, logic main_thr, logic coop,
                                     logic [BUSY_W-1:0] busy_p,
                                     logic [BUSY_W-1:0] busy_e, logic exec);
    in_t it;
    it = '0;
    it.op               = OP_CLAIM;
    it.affinity         = aff;
    it.from_main_thread = main_thr;
    it.cooperative      = coop;
    it.busy_performance = busy_p;
    it.busy_efficiency  = busy_e;
    it.executing        = exec;
    return it;
  endfunction

  // Appends a node to the tail of its queue. The links are written exactly as
  // the hardware writes them, so a node enqueued twice may merge or loop lists.
  task automatic apply_enqueue(in_t it);
    logic [1:0]        cls;
    logic [LINK_W-1:0] node;
    int                q;
    cls  = it.for_main_thread ? CLS_MAIN : it.cost_class;
    node = {1'b0, it.task_index};
    // Invalid priority, or cost code three without the main-thread target.
    if (it.priority_req == PRI_INVALID || (!it.for_main_thread && it.cost_class == CLS_MAIN)) begin
      return;
    end
    q = CLASSES_PER_PRIORITY * int'(it.priority_req) + int'(cls);
    link_mem[it.task_index] = NIL_NODE;
    if (tail_q[q] != NIL_NODE) begin
      link_mem[tail_q[q][NODE_W-1:0]] = node;
    end else begin
      head_q[q] = node;
    end
    tail_q[q] = node;
    node_queued[it.task_index] = 1'b1;
  endtask

  function automatic logic queue_eligible(logic [1:0] cls, logic [1:0] aff, in_t it);
    if (cls == CLS_MAIN) begin
      return it.from_main_thread;
    end
    if (it.from_main_thread && cfg_workers != '0 && !it.cooperative) begin
      return 1'b0;
    end
    if (!it.from_main_thread && !it.executing) begin
      return 1'b0;
    end
    if (it.cooperative || aff == AFF_ANY || cls == CLS_ANY) begin
      return 1'b1;
    end
    if (cls == CLS_HEAVY) begin
      return aff == AFF_PERF || it.busy_performance >= cfg_perf;
    end
    return aff == AFF_EFF || it.busy_efficiency >= cfg_eff;
  endfunction

  // Works out which head a claim pops, pops it and, on a grant, advances the ageing counter.
  function automatic out_t arbitrate_claim(in_t it);
    logic [1:0]        aff;
    logic [1:0]        pref;
    logic [1:0]        pri_order [3];
    logic [1:0]        cls_order [4];
    logic [LINK_W-1:0] node;
    out_t              res;
    int                n;
    int                q;
    aff = (it.affinity == AFF_RESERVED) ? AFF_ANY : it.affinity;
    // Ageing: every 32nd granted claim serves background first, the other 8th ones normal.
    if (dispatch_ctr == AGE_BACKGROUND) begin
      pri_order[0] = PRI_BACKGROUND;
    end else if (dispatch_ctr[2:0] == AGE_NORMAL) begin
      pri_order[0] = PRI_NORMAL;
    end else begin
      pri_order[0] = PRI_CRITICAL;
    end
    n = 1;
    for (int p = 0; p <= int'(PRI_BACKGROUND); p++) begin
      if (2'(p) != pri_order[0]) begin
        pri_order[n] = 2'(p);
        n++;
      end
    end
    pref         = (aff == AFF_EFF) ? CLS_LIGHT : CLS_HEAVY;
    cls_order[0] = CLS_MAIN;
    cls_order[1] = pref;
    cls_order[2] = CLS_ANY;
    cls_order[3] = (pref == CLS_HEAVY) ? CLS_LIGHT : CLS_HEAVY;
    res = NO_GRANT;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < CLASSES_PER_PRIORITY; k++) begin
        q    = CLASSES_PER_PRIORITY * int'(pri_order[p]) + int'(cls_order[k]);
        node = head_q[q];
        if (!res.granted && node != NIL_NODE && queue_eligible(cls_order[k], aff, it)) begin
          head_q[q] = link_mem[node[NODE_W-1:0]];
          if (tail_q[q] == node) begin
            tail_q[q] = NIL_NODE;
          end
          link_mem[node[NODE_W-1:0]] = NIL_NODE;
          dispatch_ctr      = dispatch_ctr + DISPATCH_W'(1);
          res.granted       = 1'b1;
          res.granted_index = node[NODE_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // Presents one item from a falling edge until its transfer, then updates the
  // predictor. Returns at the following falling edge with start still high, so
  // a back-to-back item keeps it high without a glitch.
  task automatic transfer_item(in_t it, logic typed, out_t typed_grant);
    out_t grant;
    start   = 1'b1;
    in_data = it;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    if (it.op == OP_CLAIM) begin
      grant = arbitrate_claim(it);
      if (grant.granted) begin
        node_queued[grant.granted_index] = 1'b0;
      end
      if (typed) begin
        grant = typed_grant;
      end
      expected_grants = {expected_grants, grant};
    end else begin
      apply_enqueue(it);
    end
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    case (idx)
      CFG_WORKER_COUNT: cfg_workers = value;
      CFG_PERF_WORKERS: cfg_perf    = value;
      CFG_EFF_WORKERS:  cfg_eff     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops sending, waits for every outstanding grant, then lets the block go quiet.
  task automatic settle_idle();
    start = 1'b0;
    while (expected_grants.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int plan_value(int planned);
    return (planned < 0) ? int'($urandom_range(64, 0)) : planned;
  endfunction

  // Result checker: every strobe must match the oldest expected grant.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_grants.size() == 0) begin
          note_mismatch($sformatf("unexpected result: granted %0b index %0d",
                                  out_data.granted, out_data.granted_index));
        end else begin
          want = expected_grants.pop_front();
          if (out_data.granted !== want.granted ||
              out_data.granted_index !== want.granted_index) begin
            note_mismatch($sformatf("expected granted %0b index %0d, got granted %0b index %0d",
                                    want.granted, want.granted_index,
                                    out_data.granted, out_data.granted_index));
          end
        end
      end else if (out_valid !== 1'b0) begin
        note_mismatch("result strobe is unknown");
      end
    end
  end

  initial begin
    int                counted;
    int                burst;
    int                per_phase;
    int                roll;
    in_t               it;
    logic [NODE_W-1:0] idx;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      head_q[q] = NIL_NODE;
      tail_q[q] = NIL_NODE;
    end
    for (int n = 0; n < TASK_NODES; n++) begin
      link_mem[n]    = NIL_NODE;
      node_queued[n] = 1'b0;
    end
    dispatch_ctr = '0;
    cfg_workers  = '0;
    cfg_perf     = '0;
    cfg_eff      = '0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // The directed part runs with every register at zero, as after reset, so
    // the main thread may take worker tasks and no busy count can refuse one.
    write_register(CFG_WORKER_COUNT, '0);
    write_register(CFG_PERF_WORKERS, '0);
    write_register(CFG_EFF_WORKERS, '0);

    // A claim on empty queues is answered with no grant.
    add_row(claim_item(AFF_ANY, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1), 1'b1, NO_GRANT);
    // Lowest and highest node index; then an invalid priority and a cost code
    // of three without the main-thread target, both of which are dropped.
    add_row(enqueue_item(8'd0, PRI_CRITICAL, CLS_ANY, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd255, PRI_BACKGROUND, CLS_LIGHT, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd7, PRI_INVALID, CLS_ANY, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd8, PRI_NORMAL, CLS_MAIN, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd9, PRI_NORMAL, CLS_HEAVY, 1'b1), 1'b0, NO_GRANT);
    // Affinity code three acts as "any"; the main thread takes the critical task.
    add_row(claim_item(AFF_RESERVED, 1'b1, 1'b0, 7'd0, 7'd0, 1'b1), 1'b1, {1'b1, 8'd0});
    // A worker gets nothing while execution is off, even with full busy counts.
    add_row(claim_item(AFF_ANY, 1'b0, 1'b0, 7'd64, 7'd64, 1'b0), 1'b1, NO_GRANT);
    // An efficiency worker skips the main-thread queue and takes the light task.
    add_row(claim_item(AFF_EFF, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1), 1'b1, {1'b1, 8'd255});
    // The main thread alone may take the main-thread task.
    add_row(claim_item(AFF_PERF, 1'b1, 1'b0, 7'd0, 7'd0, 1'b0), 1'b1, {1'b1, 8'd9});
    // The same node queued twice makes a list that points back at itself.
    add_row(enqueue_item(8'd5, PRI_NORMAL, CLS_HEAVY, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd5, PRI_NORMAL, CLS_HEAVY, 1'b0), 1'b0, NO_GRANT);
    repeat (3) begin
      add_row(claim_item(AFF_PERF, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1), 1'b0, NO_GRANT);
    end
    // Class order per affinity within one priority.
    add_row(enqueue_item(8'd1, PRI_CRITICAL, CLS_HEAVY, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd2, PRI_CRITICAL, CLS_LIGHT, 1'b0), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd3, PRI_CRITICAL, CLS_ANY, 1'b0), 1'b0, NO_GRANT);
    add_row(claim_item(AFF_EFF, 1'b0, 1'b1, 7'd64, 7'd0, 1'b1), 1'b0, NO_GRANT);
    add_row(claim_item(AFF_ANY, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1), 1'b0, NO_GRANT);
    add_row(claim_item(AFF_PERF, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1), 1'b0, NO_GRANT);
    add_row(enqueue_item(8'd6, PRI_BACKGROUND, CLS_ANY, 1'b1), 1'b0, NO_GRANT);
    add_row(claim_item(AFF_RESERVED, 1'b1, 1'b1, 7'd64, 7'd64, 1'b0), 1'b0, NO_GRANT);

    foreach (directed_rows[r]) begin
      transfer_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].grant);
    end

    // Random phases, each under its own register setting. The sender works in
    // bursts with gaps of random length, and some bursts run straight on.
    per_phase = ITEM_TOTAL / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      write_register(CFG_WORKER_COUNT, CFG_W'(plan_value(workers_plan[ph])));
      write_register(CFG_PERF_WORKERS, CFG_W'(plan_value(perf_plan[ph])));
      write_register(CFG_EFF_WORKERS, CFG_W'(plan_value(eff_plan[ph])));
      counted = 0;
      while (counted < per_phase) begin
        burst = $urandom_range(24, 1);
        while (burst > 0 && counted < per_phase) begin
          roll = $urandom_range(99, 0);
          if (roll < 4) begin
            // Noise: enqueues that the block must drop.
            if ($urandom_range(1, 0) == 0) begin
              it = enqueue_item(8'($urandom_range(255, 0)), PRI_INVALID,
                                2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
            end else begin
              it = enqueue_item(8'($urandom_range(255, 0)), 2'($urandom_range(2, 0)),
                                CLS_MAIN, 1'b0);
            end
          end else if (roll < 46) begin
            // Mostly free nodes; now and then a node that may already be queued.
            idx = 8'($urandom_range(255, 0));
            if ($urandom_range(9, 0) != 0) begin
              repeat (8) begin
                if (node_queued[idx]) begin
                  idx = 8'($urandom_range(255, 0));
                end
              end
            end
            it = enqueue_item(idx, 2'($urandom_range(2, 0)), 2'($urandom_range(2, 0)),
                              $urandom_range(99, 0) < 15);
            counted++;
          end else begin
            it = claim_item(2'($urandom_range(3, 0)), $urandom_range(99, 0) < 20,
                            $urandom_range(99, 0) < 30, 7'($urandom_range(64, 0)),
                            7'($urandom_range(64, 0)), $urandom_range(99, 0) < 85);
            counted++;
          end
          transfer_item(it, 1'b0, NO_GRANT);
          burst--;
        end
        if ($urandom_range(3, 0) != 0) begin
          start = 1'b0;
          repeat ($urandom_range(6, 1)) @(negedge clk);
        end
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
